// File: rtl/tmsort_pkg.sv
package tmsort_pkg;

  localparam int unsigned MaxItemsDef = 16;
  localparam int unsigned MomBitsDef  = 24;
  localparam int unsigned EnergyBits  = 24;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: rtl/tmsort_key.sv
module tmsort_key #(
  parameter int unsigned MOM_BITS = tmsort_pkg::MomBitsDef,
  parameter int unsigned DATA_W   = 3 * MOM_BITS + tmsort_pkg::EnergyBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic                    last_i,
  input  logic [DATA_W-1:0]       data_i,
  output logic                    valid_o,
  output logic                    last_o,
  output logic [DATA_W-1:0]       data_o,
  output logic [2*MOM_BITS:0]     key_o
);

  logic signed [MOM_BITS-1:0] mom_x, mom_y;
  logic [MOM_BITS-1:0]        abs_x, abs_y;

  logic                    s1_valid_q, s2_valid_q;
  logic                    s1_last_q, s2_last_q;
  logic [DATA_W-1:0]       s1_data_q, s2_data_q;
  logic [2*MOM_BITS-1:0]   sq_x_q, sq_y_q;
  logic [2*MOM_BITS:0]     key_q;

  assign mom_x = data_i[MOM_BITS-1:0];
  assign mom_y = data_i[2*MOM_BITS-1:MOM_BITS];
  // the most negative value maps onto its magnitude as an unsigned number
  assign abs_x = mom_x[MOM_BITS-1] ? MOM_BITS'(-mom_x) : MOM_BITS'(mom_x);
  assign abs_y = mom_y[MOM_BITS-1] ? MOM_BITS'(-mom_y) : MOM_BITS'(mom_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= last_i;
    s1_data_q <= data_i;
    sq_x_q    <= abs_x * abs_x;
    sq_y_q    <= abs_y * abs_y;
    s2_last_q <= s1_last_q;
    s2_data_q <= s1_data_q;
    key_q     <= {1'b0, sq_x_q} + {1'b0, sq_y_q};
  end

  assign valid_o = s2_valid_q;
  assign last_o  = s2_last_q;
  assign data_o  = s2_data_q;
  assign key_o   = key_q;

endmodule

// File: rtl/tmsort_cell.sv
module tmsort_cell #(
  parameter int unsigned KEY_W  = 49,
  parameter int unsigned DATA_W = 96
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tmsort_pkg::cell_ctrl_t ctrl_i,
  input  logic [KEY_W-1:0]       new_key_i,
  input  logic [DATA_W-1:0]      new_data_i,
  input  logic                   ins_prev_i,
  input  logic                   left_valid_i,
  input  logic [KEY_W-1:0]       left_key_i,
  input  logic [DATA_W-1:0]      left_data_i,
  input  logic                   right_valid_i,
  input  logic [KEY_W-1:0]       right_key_i,
  input  logic [DATA_W-1:0]      right_data_i,
  output logic                   ins_o,
  output logic                   valid_o,
  output logic [KEY_W-1:0]       key_o,
  output logic [DATA_W-1:0]      data_o
);

  logic              valid_d, valid_q;
  logic [KEY_W-1:0]  key_d, key_q;
  logic [DATA_W-1:0] data_d, data_q;

  // newer word goes ahead of an equal key
  assign ins_o = ctrl_i.insert && (!valid_q || (new_key_i >= key_q));

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    if (ctrl_i.shift) begin
      valid_d = right_valid_i;
      key_d   = right_key_i;
      data_d  = right_data_i;
    end else if (ins_o) begin
      if (ins_prev_i) begin
        valid_d = left_valid_i;
        key_d   = left_key_i;
        data_d  = left_data_i;
      end else begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        data_d  = new_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign data_o  = data_q;

endmodule

// File: rtl/transverse_momentum_sorter.sv
// sorts one set of particle four-vectors by descending transverse momentum
// s_axis: one vector per word, tdata = {energy, mom_z, mom_y, mom_x}, tlast
//   marks the final vector of the set
// m_axis: the sorted set, largest px*px+py*py first, equal keys newest first;
//   tlast on the final word, tuser = 1 on every word of a set that lost a vector
// filling takes one word per cycle; words past MAX_ITEMS are discarded
// the key pipeline registers the squares and then their sum, and vectors then enter a chain of
// MAX_ITEMS cells that keeps them ordered on insertion
// after the marked word the input stalls; once that word has passed the key pipeline into
// the chain, the sorted words leave its head through the output register, one word per
// cycle while the receiver is ready
// when the receiver stalls the chain holds still and the output word stays
// input is taken again once the final sorted word sits in the output register
// reset empties the chain and drops any set in progress
module transverse_momentum_sorter #(
  parameter int unsigned MAX_ITEMS = tmsort_pkg::MaxItemsDef,
  parameter int unsigned MOM_BITS  = tmsort_pkg::MomBitsDef,
  localparam int unsigned DataW    = 3 * MOM_BITS + tmsort_pkg::EnergyBits,
  localparam int unsigned BusW     = ((DataW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [BusW-1:0] s_axis_tdata_i,   // mom_x, mom_y, mom_z, energy, zero fill
  input  logic            s_axis_tlast_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [BusW-1:0] m_axis_tdata_o,   // out_mom_x, out_mom_y, out_mom_z, out_energy, zero fill
  output logic            m_axis_tlast_o,
  output logic            m_axis_tuser_o    // dropped
);

  localparam int unsigned KeyW = 2 * MOM_BITS + 1;
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  logic              in_acc;
  logic              k_valid, k_last;
  logic [DataW-1:0]  k_data;
  logic [KeyW-1:0]   k_key;

  logic [CntW-1:0]   cnt_d, cnt_q;
  logic              busy_d, busy_q;
  logic              drain_d, drain_q;
  logic              ovf_d, ovf_q;
  logic              full, shift, final_shift;

  logic              m_valid_d, m_valid_q;
  logic              m_last_q, m_user_q;
  logic [DataW-1:0]  m_data_q;

  tmsort_pkg::cell_ctrl_t ctrl;

  // chain views padded with an empty slot at either end; ins_ext only at the head
  logic              ins_ext   [0:MAX_ITEMS];
  logic              valid_ext [0:MAX_ITEMS+1];
  logic [KeyW-1:0]   key_ext   [0:MAX_ITEMS+1];
  logic [DataW-1:0]  data_ext  [0:MAX_ITEMS+1];

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !busy_q;

  tmsort_key #(
    .MOM_BITS (MOM_BITS),
    .DATA_W   (DataW)
  ) u_key (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_acc),
    .last_i  (s_axis_tlast_i),
    .data_i  (s_axis_tdata_i[DataW-1:0]),
    .valid_o (k_valid),
    .last_o  (k_last),
    .data_o  (k_data),
    .key_o   (k_key)
  );

  assign full        = (cnt_q == CntW'(MAX_ITEMS));
  assign shift       = drain_q && (!m_valid_q || m_axis_tready_i);
  assign final_shift = shift && (cnt_q == CntW'(1));
  assign ctrl.insert = k_valid && !full;
  assign ctrl.shift  = shift;

  assign ins_ext[0]              = 1'b0;
  assign valid_ext[0]            = 1'b0;
  assign key_ext[0]              = '0;
  assign data_ext[0]             = '0;
  assign valid_ext[MAX_ITEMS+1]  = 1'b0;
  assign key_ext[MAX_ITEMS+1]    = '0;
  assign data_ext[MAX_ITEMS+1]   = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    tmsort_cell #(
      .KEY_W  (KeyW),
      .DATA_W (DataW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_key_i     (k_key),
      .new_data_i    (k_data),
      .ins_prev_i    (ins_ext[i]),
      .left_valid_i  (valid_ext[i]),
      .left_key_i    (key_ext[i]),
      .left_data_i   (data_ext[i]),
      .right_valid_i (valid_ext[i+2]),
      .right_key_i   (key_ext[i+2]),
      .right_data_i  (data_ext[i+2]),
      .ins_o         (ins_ext[i+1]),
      .valid_o       (valid_ext[i+1]),
      .key_o         (key_ext[i+1]),
      .data_o        (data_ext[i+1])
    );
  end

  always_comb begin
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    drain_d = drain_q;
    ovf_d   = ovf_q;
    if (in_acc && s_axis_tlast_i) begin
      busy_d = 1'b1;
    end
    if (k_valid) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
      if (k_last) begin
        drain_d = 1'b1;
      end
    end
    if (shift) begin
      cnt_d = cnt_q - CntW'(1);
    end
    if (final_shift) begin
      drain_d = 1'b0;
      busy_d  = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (shift) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      busy_q    <= 1'b0;
      drain_q   <= 1'b0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      busy_q    <= busy_d;
      drain_q   <= drain_d;
      ovf_q     <= ovf_d;
      m_valid_q <= m_valid_d;
    end
  end

  // output word taken from the head of the chain
  always_ff @(posedge clk_i) begin
    if (shift) begin
      m_data_q <= data_ext[1];
      m_last_q <= (cnt_q == CntW'(1));
      m_user_q <= ovf_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = BusW'(m_data_q);
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

// File: tb/tmsort_checker.sv
`timescale 1ns / 100ps

module tmsort_checker #(
  localparam int unsigned BusW =
    ((3 * tmsort_pkg::MomBitsDef + tmsort_pkg::EnergyBits + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  input  logic            s_axis_tready_i,
  input  logic [BusW-1:0] s_axis_tdata_i,   // mom_x, mom_y, mom_z, energy, zero fill
  input  logic            s_axis_tlast_i,
  input  logic            m_axis_tvalid_i,
  input  logic            m_axis_tready_i,
  input  logic [BusW-1:0] m_axis_tdata_i,   // out_mom_x, out_mom_y, out_mom_z, out_energy
  input  logic            m_axis_tlast_i,
  input  logic            m_axis_tuser_i,   // dropped
  output int              fail_count_o,
  output int              pending_o,
  output int              words_checked_o
);

  // packed so that mom_x lands in the lowest bits, as on the bus
  typedef struct packed {
    logic [tmsort_pkg::EnergyBits-1:0]        energy;
    logic signed [tmsort_pkg::MomBitsDef-1:0] mom_z;
    logic signed [tmsort_pkg::MomBitsDef-1:0] mom_y;
    logic signed [tmsort_pkg::MomBitsDef-1:0] mom_x;
  } four_vec_t;

  typedef struct {
    four_vec_t vec;
    logic      run_end;
    logic      dropped;
  } sorted_word_t;

  four_vec_t         held_vec [tmsort_pkg::MaxItemsDef];
  longint unsigned   held_key [tmsort_pkg::MaxItemsDef];
  int unsigned       held_cnt;
  logic              lost_one;
  sorted_word_t      sorted_q [$];
  sorted_word_t      want;
  four_vec_t         got_vec;
  four_vec_t         in_vec;

  function automatic longint unsigned pt_squared(
      logic signed [tmsort_pkg::MomBitsDef-1:0] px,
      logic signed [tmsort_pkg::MomBitsDef-1:0] py);
    longint sx;
    longint sy;
    sx = px;
    sy = py;
    if (sx < 0) sx = -sx;
    if (sy < 0) sy = -sy;
    return longint'(sx * sx + sy * sy);
  endfunction

  // rank by key, equal keys newest first
  task automatic queue_sorted_set();
    sorted_word_t ranked [tmsort_pkg::MaxItemsDef];
    int unsigned  rank;
    for (int i = 0; i < int'(held_cnt); i++) begin
      rank = 0;
      for (int j = 0; j < int'(held_cnt); j++) begin
        if (held_key[j] > held_key[i] || (held_key[j] == held_key[i] && j > i)) rank++;
      end
      ranked[rank].vec     = held_vec[i];
      ranked[rank].run_end = (rank == held_cnt - 1);
      ranked[rank].dropped = lost_one;
    end
    for (int r = 0; r < int'(held_cnt); r++) sorted_q.insert(sorted_q.size(), ranked[r]);
  endtask

  task automatic check_field(string name, logic [23:0] exp_val, logic [23:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s expected %h, got %h", $time, name, exp_val, got_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt        = 0;
      lost_one        = 1'b0;
      sorted_q.delete();
      fail_count_o    = 0;
      pending_o       = 0;
      words_checked_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_vec = m_axis_tdata_i[$bits(four_vec_t)-1:0];
        if (sorted_q.size() == 0) begin
          $display("%0t: word %h with no expected word, expected none", $time,
                   m_axis_tdata_i);
          fail_count_o++;
        end else begin
          want = sorted_q.pop_front();
          check_field("mom_x", want.vec.mom_x, got_vec.mom_x);
          check_field("mom_y", want.vec.mom_y, got_vec.mom_y);
          check_field("mom_z", want.vec.mom_z, got_vec.mom_z);
          check_field("energy", want.vec.energy, got_vec.energy);
          check_field("run_end", 24'(want.run_end), 24'(m_axis_tlast_i));
          check_field("dropped", 24'(want.dropped), 24'(m_axis_tuser_i));
          if ((m_axis_tdata_i >> $bits(four_vec_t)) != '0) begin
            $display("%0t: fill bits expected 0, got %h", $time, m_axis_tdata_i);
            fail_count_o++;
          end
          words_checked_o++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        in_vec = s_axis_tdata_i[$bits(four_vec_t)-1:0];
        if (held_cnt < tmsort_pkg::MaxItemsDef) begin
          held_vec[held_cnt] = in_vec;
          held_key[held_cnt] = pt_squared(in_vec.mom_x, in_vec.mom_y);
          held_cnt++;
        end else begin
          lost_one = 1'b1;
        end
        if (s_axis_tlast_i) begin
          queue_sorted_set();
          held_cnt = 0;
          lost_one = 1'b0;
        end
      end
      pending_o = sorted_q.size();
    end
  end

endmodule

// File: tb/transverse_momentum_sorter_tb.sv
`timescale 1ns / 100ps

module transverse_momentum_sorter_tb;

  localparam int unsigned MomBits       = tmsort_pkg::MomBitsDef;
  localparam int unsigned EnBits        = tmsort_pkg::EnergyBits;
  localparam int unsigned MaxItems      = tmsort_pkg::MaxItemsDef;
  localparam int unsigned BusW          = ((3 * MomBits + EnBits + 7) / 8) * 8;
  localparam int unsigned RandomVecs    = 75;
  localparam int unsigned HoldOffWords  = 30;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned DrainCycles   = 40;

  logic            clk      = 1'b0;
  logic            rst_n    = 1'b0;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [BusW-1:0] s_tdata  = '0;
  logic            s_tlast  = 1'b0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [BusW-1:0] m_tdata;
  logic            m_tlast;
  logic            m_tuser;

  int fail_count;
  int pending;
  int words_checked;
  int vecs_sent;
  int sets_sent;
  int full_sets;
  int set_fill;
  int directed_vecs;

  transverse_momentum_sorter dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  tmsort_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .m_axis_tuser_i  (m_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [23:0] rand24();
    logic [31:0] r;
    r = $urandom;
    return r[23:0];
  endfunction

  task automatic send_vec(input logic [MomBits-1:0] px, input logic [MomBits-1:0] py,
                          input logic [MomBits-1:0] pz, input logic [EnBits-1:0] en,
                          input logic mark, input bit no_gaps);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= BusW'({en, pz, py, px});
    s_tlast  <= mark;
    do @(posedge clk); while (!s_tready);
    vecs_sent++;
    set_fill++;
    if (mark) begin
      sets_sent++;
      if (set_fill > int'(MaxItems)) full_sets++;
      set_fill = 0;
    end
  endtask

  // tie-prone sets keep px and py tiny so that equal keys are common
  task automatic send_random_set(input int unsigned len, input bit tie_prone,
                                 input bit no_gaps);
    logic [23:0] px;
    logic [23:0] py;
    int          s;
    for (int k = 0; k < int'(len); k++) begin
      if (tie_prone) begin
        s  = $urandom_range(0, 6);
        px = 24'(s - 3);
        s  = $urandom_range(0, 6);
        py = 24'(s - 3);
      end else begin
        px = rand24();
        py = rand24();
      end
      send_vec(px, py, rand24(), rand24(), k == int'(len) - 1, no_gaps);
    end
  endtask

  // receiver: random stalls, bursts of back-to-back words, one long hold-off
  initial begin : drain
    int unsigned gap;
    int unsigned burst_left;
    int unsigned words_taken;
    burst_left  = 0;
    words_taken = 0;
    @(posedge rst_n);
    forever begin
      if (words_taken == HoldOffWords) begin
        gap = HoldOffCycles;
      end else if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(8, 24);
        gap        = 0;
      end else begin
        gap = $urandom_range(0, 13);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      words_taken++;
    end
  end

  initial begin
    vecs_sent = 0;
    sets_sent = 0;
    full_sets = 0;
    set_fill  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone vector at the field extremes
    send_vec(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 1'b1, 1'b0);

    // four equal keys and a zero vector, back to back
    send_vec(24'd3, 24'd4, 24'h800000, 24'h000000, 1'b0, 1'b1);
    send_vec(24'(-4), 24'd3, 24'h800000, 24'h000000, 1'b0, 1'b1);
    send_vec(24'd5, 24'd0, 24'h800000, 24'h000000, 1'b0, 1'b1);
    send_vec(24'd0, 24'(-5), 24'h800000, 24'h000000, 1'b0, 1'b1);
    send_vec(24'd0, 24'd0, 24'h800000, 24'h000000, 1'b1, 1'b1);

    // one past capacity, the marked word finds the store full
    for (int k = 0; k < int'(MaxItems) + 1; k++) begin
      if (k == 0)
        send_vec(24'h800000, 24'h800000, rand24(), rand24(), 1'b0, 1'b0);
      else if (k == 5)
        send_vec(24'h7FFFFF, 24'h7FFFFF, rand24(), rand24(), 1'b0, 1'b0);
      else
        send_vec(rand24(), rand24(), rand24(), rand24(), k == int'(MaxItems), 1'b0);
    end
    directed_vecs = vecs_sent;

    while (vecs_sent < directed_vecs + int'(RandomVecs)) begin
      send_random_set(($urandom_range(0, 4) == 0) ? $urandom_range(MaxItems + 1, 20)
                                                  : $urandom_range(1, MaxItems),
                      $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0);
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("tb: %0d vectors in %0d sets, %0d over capacity; %0d sorted words checked",
             vecs_sent, sets_sent, full_sets, words_checked);
    $display("tb: output held off %0d cycles once to back up the input", HoldOffCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      if (pending != 0) $display("%0t: %0d sorted words never arrived", $time, pending);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
